>>> hdl/lbps_pkg.sv
// types and constants shared by the led blink pattern sequencer
`timescale 1ns / 1ps
`default_nettype none

package lbps_pkg;

    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = 3;
    localparam int REG_STEPS  = 4;
    localparam int CFG_TIME_W = 16;
    localparam int COUNT_W    = 3;

    localparam logic [COUNT_W-1:0]    STEP_COUNT_RST   = 3'd2;
    localparam logic [REG_STEPS-1:0]  STEP_LEVELS_RST  = 4'd0;
    localparam logic [CFG_TIME_W-1:0] DEFAULT_TIME     = 16'd500;
    localparam logic                  INVERT_RST       = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_STEP_COUNT  = 3'd0,
        REG_STEP_LEVELS = 3'd1,
        REG_STEP_TIME_0 = 3'd2,
        REG_STEP_TIME_1 = 3'd3,
        REG_STEP_TIME_2 = 3'd4,
        REG_STEP_TIME_3 = 3'd5,
        REG_INVERT      = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_MANUAL  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef struct packed {
        op_t  operation;
        logic manual_level;
    } in_t;

    typedef struct packed {
        logic       pin_level;
        logic [1:0] current_step;
    } out_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                     step_count;
        logic [REG_STEPS-1:0]                   step_levels;
        logic [REG_STEPS-1:0][CFG_TIME_W-1:0]   step_time;
        logic                                   invert_output;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/lbps_regs.sv
// apb configuration registers of the led blink pattern sequencer
`timescale 1ns / 1ps
`default_nettype none

module lbps_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lbps_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lbps_pkg::DATA_W-1:0]   pwdata,
    output logic      [lbps_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output lbps_pkg::cfg_t                     cfg
);

    lbps_pkg::cfg_t               cfg_reg;
    lbps_pkg::reg_idx_t           idx;
    logic                         wr_en;

    assign idx    = lbps_pkg::reg_idx_t'(paddr[lbps_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_count    <= lbps_pkg::STEP_COUNT_RST;
            cfg_reg.step_levels   <= lbps_pkg::STEP_LEVELS_RST;
            for (int k = 0; k < lbps_pkg::REG_STEPS; k++) begin
                cfg_reg.step_time[k] <= lbps_pkg::DEFAULT_TIME;
            end
            cfg_reg.invert_output <= lbps_pkg::INVERT_RST;
        end else if (wr_en) begin
            case (idx)
                lbps_pkg::REG_STEP_COUNT: begin
                    cfg_reg.step_count <= pwdata[lbps_pkg::COUNT_W-1:0];
                end
                lbps_pkg::REG_STEP_LEVELS: begin
                    cfg_reg.step_levels <= pwdata[lbps_pkg::REG_STEPS-1:0];
                end
                lbps_pkg::REG_STEP_TIME_0: begin
                    cfg_reg.step_time[0] <= pwdata[lbps_pkg::CFG_TIME_W-1:0];
                end
                lbps_pkg::REG_STEP_TIME_1: begin
                    cfg_reg.step_time[1] <= pwdata[lbps_pkg::CFG_TIME_W-1:0];
                end
                lbps_pkg::REG_STEP_TIME_2: begin
                    cfg_reg.step_time[2] <= pwdata[lbps_pkg::CFG_TIME_W-1:0];
                end
                lbps_pkg::REG_STEP_TIME_3: begin
                    cfg_reg.step_time[3] <= pwdata[lbps_pkg::CFG_TIME_W-1:0];
                end
                lbps_pkg::REG_INVERT: begin
                    cfg_reg.invert_output <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            lbps_pkg::REG_STEP_COUNT: begin
                prdata = lbps_pkg::DATA_W'(cfg_reg.step_count);
            end
            lbps_pkg::REG_STEP_LEVELS: begin
                prdata = lbps_pkg::DATA_W'(cfg_reg.step_levels);
            end
            lbps_pkg::REG_STEP_TIME_0: begin
                prdata = lbps_pkg::DATA_W'(cfg_reg.step_time[0]);
            end
            lbps_pkg::REG_STEP_TIME_1: begin
                prdata = lbps_pkg::DATA_W'(cfg_reg.step_time[1]);
            end
            lbps_pkg::REG_STEP_TIME_2: begin
                prdata = lbps_pkg::DATA_W'(cfg_reg.step_time[2]);
            end
            lbps_pkg::REG_STEP_TIME_3: begin
                prdata = lbps_pkg::DATA_W'(cfg_reg.step_time[3]);
            end
            lbps_pkg::REG_INVERT: begin
                prdata = lbps_pkg::DATA_W'(cfg_reg.invert_output);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/led_blink_pattern_sequencer_unit.sv
// a word's result is in the output register in the cycle after it is accepted
// one word per cycle while the receiver holds m_ready high, the output register is refilled as it drains
// the sequencer state and output register update in a single pass at accept
// reset: step index 0, countdown 0 so the first tick fires, auto mode,
// pin at the led off level, configuration at its reset values
`timescale 1ns / 1ps
`default_nettype none

module led_blink_pattern_sequencer_unit #(
    parameter int MAX_STEPS  = 4,
    parameter int TIME_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lbps_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lbps_pkg::DATA_W-1:0]   pwdata,
    output logic      [lbps_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire lbps_pkg::in_t                 s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output lbps_pkg::out_t                     m_data
);

    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    lbps_pkg::cfg_t          cfg;
    logic [TIME_WIDTH-1:0]   time_vec [MAX_STEPS];
    logic [MAX_STEPS-1:0]    level_vec;

    logic [IDX_W-1:0]        step_index_reg, step_index_next;
    logic [TIME_WIDTH-1:0]   ticks_left_reg, ticks_left_next;
    logic                    manual_mode_reg, manual_mode_next;
    logic                    restart_pending_reg, restart_pending_next;
    logic                    pin_reg, pin_next;
    logic                    m_valid_reg;
    lbps_pkg::out_t          m_data_reg;

    logic [CNT_W-1:0]        eff_cnt;
    logic [IDX_W-1:0]        fire_idx;
    logic [CNT_W-1:0]        idx_inc;
    logic [TIME_WIDTH-1:0]   fire_time;
    logic                    accept;

    lbps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // step table, steps past the register set stay off at the default time
    for (genvar k = 0; k < MAX_STEPS; k++) begin : g_step
        if (k < lbps_pkg::REG_STEPS) begin : g_cfg
            assign level_vec[k] = cfg.step_levels[k];
            assign time_vec[k]  = TIME_WIDTH'(cfg.step_time[k]);
        end else begin : g_fixed
            assign level_vec[k] = 1'b0;
            assign time_vec[k]  = TIME_WIDTH'(lbps_pkg::DEFAULT_TIME);
        end
    end

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (cfg.step_count == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (int'(cfg.step_count) > MAX_STEPS) begin
            eff_cnt = CNT_W'(MAX_STEPS);
        end else begin
            eff_cnt = CNT_W'(cfg.step_count);
        end

        fire_idx = restart_pending_reg ? '0 : step_index_reg;
        if (CNT_W'(fire_idx) >= eff_cnt) begin
            fire_idx = '0;
        end
        fire_time = time_vec[fire_idx];
        idx_inc   = CNT_W'(fire_idx) + CNT_W'(1);
    end

    always_comb begin
        step_index_next      = step_index_reg;
        ticks_left_next      = ticks_left_reg;
        manual_mode_next     = manual_mode_reg;
        restart_pending_next = restart_pending_reg;
        pin_next             = pin_reg;
        case (s_data.operation)
            lbps_pkg::OP_TICK: begin
                if (ticks_left_reg == '0) begin
                    restart_pending_next = 1'b0;
                    if (!manual_mode_reg) begin
                        pin_next = level_vec[fire_idx] ^ cfg.invert_output;
                    end
                    ticks_left_next = (fire_time == '0) ? '0 : fire_time - 1'b1;
                    step_index_next = (idx_inc >= eff_cnt) ? '0 : idx_inc[IDX_W-1:0];
                end else begin
                    ticks_left_next = ticks_left_reg - 1'b1;
                end
            end
            lbps_pkg::OP_MANUAL: begin
                manual_mode_next = 1'b1;
                pin_next         = s_data.manual_level ^ cfg.invert_output;
            end
            lbps_pkg::OP_RELEASE: begin
                manual_mode_next = 1'b0;
            end
            lbps_pkg::OP_RESTART: begin
                restart_pending_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_index_reg      <= '0;
            ticks_left_reg      <= '0;
            manual_mode_reg     <= 1'b0;
            restart_pending_reg <= 1'b0;
            pin_reg             <= lbps_pkg::INVERT_RST;
            m_valid_reg         <= 1'b0;
        end else begin
            if (accept) begin
                step_index_reg      <= step_index_next;
                ticks_left_reg      <= ticks_left_next;
                manual_mode_reg     <= manual_mode_next;
                restart_pending_reg <= restart_pending_next;
                pin_reg             <= pin_next;
                m_valid_reg         <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.pin_level    <= pin_next;
            m_data_reg.current_step <= restart_pending_next ? 2'd0 : 2'(step_index_next);
        end
    end

endmodule

`default_nettype wire

>>> sim/led_blink_pattern_sequencer_unit_tb.sv
// testbench for the led blink pattern sequencer with its own pattern predictor and scoreboard
`timescale 1ns / 1ps

module led_blink_pattern_sequencer_unit_tb;

    localparam int IDLE_LIMIT = 4000;
    localparam logic [lbps_pkg::REG_IDX_W-1:0] REG_UNUSED_IDX = 3'd7;

    class blink_scoreboard;
        logic [lbps_pkg::COUNT_W-1:0]    cfg_count;
        logic [lbps_pkg::REG_STEPS-1:0]  cfg_levels;
        logic [lbps_pkg::CFG_TIME_W-1:0] cfg_dur [lbps_pkg::REG_STEPS];
        logic                            cfg_invert;
        int unsigned                     step_idx;
        logic [lbps_pkg::CFG_TIME_W-1:0] countdown;
        bit                              manual_on;
        bit                              restart_on;
        logic                            pin;
        lbps_pkg::out_t                  expected_q [$];
        int                              errors;

        function new();
            cfg_count  = lbps_pkg::STEP_COUNT_RST;
            cfg_levels = lbps_pkg::STEP_LEVELS_RST;
            foreach (cfg_dur[k]) cfg_dur[k] = lbps_pkg::DEFAULT_TIME;
            cfg_invert = lbps_pkg::INVERT_RST;
            step_idx   = 0;
            countdown  = '0;
            manual_on  = 1'b0;
            restart_on = 1'b0;
            pin        = lbps_pkg::INVERT_RST;
            errors     = 0;
        endfunction

        function void set_reg(logic [lbps_pkg::REG_IDX_W-1:0] idx,
                              logic [lbps_pkg::DATA_W-1:0] v);
            case (idx)
                lbps_pkg::REG_STEP_COUNT:  cfg_count = v[lbps_pkg::COUNT_W-1:0];
                lbps_pkg::REG_STEP_LEVELS: cfg_levels = v[lbps_pkg::REG_STEPS-1:0];
                lbps_pkg::REG_STEP_TIME_0, lbps_pkg::REG_STEP_TIME_1,
                lbps_pkg::REG_STEP_TIME_2, lbps_pkg::REG_STEP_TIME_3: begin
                    cfg_dur[idx - lbps_pkg::REG_STEP_TIME_0] = v[lbps_pkg::CFG_TIME_W-1:0];
                end
                lbps_pkg::REG_INVERT:      cfg_invert = v[0];
                default: ;
            endcase
        endfunction

        function void fire_step();
            int unsigned n;
            n = (cfg_count == 0) ? 1 :
                (cfg_count > lbps_pkg::REG_STEPS) ? lbps_pkg::REG_STEPS : cfg_count;
            if (restart_on) begin
                restart_on = 1'b0;
                step_idx = 0;
            end
            if (step_idx >= n) step_idx = 0;
            if (!manual_on) pin = cfg_levels[step_idx] ^ cfg_invert;
            countdown = (cfg_dur[step_idx] == 0) ? '0 : cfg_dur[step_idx] - 1'b1;
            step_idx++;
            if (step_idx >= n) step_idx = 0;
        endfunction

        function void note_word(lbps_pkg::in_t w);
            lbps_pkg::out_t e;
            case (w.operation)
                lbps_pkg::OP_TICK: begin
                    if (countdown == 0) fire_step();
                    else countdown = countdown - 1'b1;
                end
                lbps_pkg::OP_MANUAL: begin
                    manual_on = 1'b1;
                    pin = w.manual_level ^ cfg_invert;
                end
                lbps_pkg::OP_RELEASE: manual_on = 1'b0;
                default:    restart_on = 1'b1;
            endcase
            e.pin_level    = pin;
            e.current_step = restart_on ? 2'd0 : step_idx[1:0];
            expected_q.push_back(e);
        endfunction

        function void check_word(lbps_pkg::out_t got);
            lbps_pkg::out_t e;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result word: actual pin %b step %0d",
                         $time, got.pin_level, got.current_step);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.pin_level !== e.pin_level) begin
                $display("%0t pin_level mismatch: expected %b actual %b",
                         $time, e.pin_level, got.pin_level);
                errors++;
            end
            if (got.current_step !== e.current_step) begin
                $display("%0t current_step mismatch: expected %0d actual %0d",
                         $time, e.current_step, got.current_step);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [lbps_pkg::ADDR_W-1:0] paddr   = '0;
    logic [lbps_pkg::DATA_W-1:0] pwdata  = '0;
    logic [lbps_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    lbps_pkg::in_t               s_data  = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    lbps_pkg::out_t              m_data;

    blink_scoreboard sb = new();
    int idle_cycles = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int rcv_cyc     = 0;

    led_blink_pattern_sequencer_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_word(s_data);
            if (m_valid && m_ready) sb.check_word(m_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 150);
        end
        mode_left--;
        rcv_cyc++;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 99) < 70);
            2: m_ready <= ((rcv_cyc % 5) != 0);
            default: m_ready <= ($urandom_range(0, 99) < 30);
        endcase
    end

    task automatic write_reg(input logic [lbps_pkg::REG_IDX_W-1:0] idx,
                             input logic [lbps_pkg::DATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lbps_pkg::ADDR_W'(idx * 4);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_word(input lbps_pkg::in_t w);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_for(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    function automatic lbps_pkg::in_t rand_word();
        lbps_pkg::in_t w;
        int r;
        r = $urandom_range(0, 99);
        w.operation = (r < 60) ? lbps_pkg::OP_TICK : (r < 74) ? lbps_pkg::OP_MANUAL :
                      (r < 88) ? lbps_pkg::OP_RELEASE : lbps_pkg::OP_RESTART;
        w.manual_level = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic lbps_pkg::in_t mk_word(input lbps_pkg::op_t op, input logic lvl);
        lbps_pkg::in_t w;
        w.operation    = op;
        w.manual_level = lvl;
        return w;
    endfunction

    task automatic send_items(input int n, input bit gapless);
        int burst_left;
        burst_left = 0;
        for (int i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (!gapless && $urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
            end
            send_word(rand_word());
            burst_left--;
        end
        idle_for(1);
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    function automatic logic [lbps_pkg::CFG_TIME_W-1:0] rand_dur();
        if ($urandom_range(0, 15) == 0) return lbps_pkg::CFG_TIME_W'($urandom_range(50, 300));
        return lbps_pkg::CFG_TIME_W'($urandom_range(0, 6));
    endfunction

    task automatic configure(input int p);
        logic [lbps_pkg::COUNT_W-1:0]    cnt;
        logic [lbps_pkg::REG_STEPS-1:0]  lv;
        logic [lbps_pkg::CFG_TIME_W-1:0] dur [lbps_pkg::REG_STEPS];
        logic                            inv;
        cnt = ($urandom_range(0, 4) == 0) ? lbps_pkg::COUNT_W'($urandom_range(0, 7))
                                          : lbps_pkg::COUNT_W'($urandom_range(1, 4));
        lv  = lbps_pkg::REG_STEPS'($urandom_range(0, 15));
        inv = 1'($urandom_range(0, 1));
        foreach (dur[k]) dur[k] = rand_dur();
        case (p)
            0: begin
                cnt = 3'd4;
                lv  = 4'b0110;
                inv = 1'b0;
                foreach (dur[k]) dur[k] = lbps_pkg::CFG_TIME_W'(k);
            end
            1: begin
                cnt = 3'd7;
                lv  = 4'hf;
                inv = 1'b1;
                foreach (dur[k]) dur[k] = '1;
                write_reg(REG_UNUSED_IDX, 32'hffff_ffff);
            end
            2: cnt = 3'd0;
            3: begin
                cnt = 3'd5;
                lv  = 4'h0;
            end
            4: cnt = 3'd1;
            default: ;
        endcase
        write_reg(lbps_pkg::REG_STEP_COUNT,
                  lbps_pkg::DATA_W'(cnt) | ($urandom_range(0, 1) << 8));
        write_reg(lbps_pkg::REG_STEP_LEVELS, lbps_pkg::DATA_W'(lv));
        for (int k = 0; k < lbps_pkg::REG_STEPS; k++) begin
            write_reg(lbps_pkg::REG_IDX_W'(lbps_pkg::REG_STEP_TIME_0 + k),
                      lbps_pkg::DATA_W'(dur[k]));
        end
        write_reg(lbps_pkg::REG_INVERT, lbps_pkg::DATA_W'(inv));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset configuration: first tick fires, then manual, release and restart
        send_word(mk_word(lbps_pkg::OP_TICK, 1'b0));
        send_word(mk_word(lbps_pkg::OP_TICK, 1'b1));
        send_word(mk_word(lbps_pkg::OP_MANUAL, 1'b1));
        send_word(mk_word(lbps_pkg::OP_TICK, 1'b0));
        send_word(mk_word(lbps_pkg::OP_MANUAL, 1'b0));
        send_word(mk_word(lbps_pkg::OP_MANUAL, 1'b1));
        send_word(mk_word(lbps_pkg::OP_RELEASE, 1'b1));
        send_word(mk_word(lbps_pkg::OP_TICK, 1'b0));
        send_word(mk_word(lbps_pkg::OP_RESTART, 1'b0));
        send_word(mk_word(lbps_pkg::OP_TICK, 1'b0));
        send_word(mk_word(lbps_pkg::OP_RESTART, 1'b1));
        send_word(mk_word(lbps_pkg::OP_RESTART, 1'b0));
        send_word(mk_word(lbps_pkg::OP_MANUAL, 1'b0));
        send_word(mk_word(lbps_pkg::OP_RELEASE, 1'b0));
        send_word(mk_word(lbps_pkg::OP_TICK, 1'b1));
        idle_for(1);
        wait_drain();

        for (int p = 0; p < 10; p++) begin
            configure(p);
            send_items((p == 1) ? 40 : 120, (p % 4) == 3);
            wait_drain();
        end

        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
